// File: rtl/core/vrf_pkg.sv
// Shared types, codes and address helpers for the video register file.
// Used by video_register_file_vram_port; no other dependencies.

package vrf_pkg;

    // Request command field
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVENT = 2'd2
    } t_cmd;

    // CPU-visible register numbers
    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } t_reg;

    // How the second stage forms read data and the read buffer
    typedef enum logic [2:0] {
        K_IMM,      // value known at accept
        K_SPR,      // sprite memory byte
        K_PAL,      // palette byte now, buffer from nametable
        K_BUF_PAT,  // old buffer, buffer from pattern store
        K_BUF_NT,   // old buffer, buffer from nametable
        K_CLR       // buffer cleared
    } t_kind;

    // Configuration register indexes
    localparam logic CFG_MIRROR  = 1'b0;
    localparam logic CFG_PAT_ROM = 1'b1;

    // Nametable mirroring modes
    localparam logic [1:0] MIR_ONE_A = 2'd0;
    localparam logic [1:0] MIR_ONE_B = 2'd1;
    localparam logic [1:0] MIR_VERT  = 2'd2;
    localparam logic [1:0] MIR_HORZ  = 2'd3;

    // VRAM map
    localparam logic [13:0] NT_BASE  = 14'h2000;
    localparam logic [13:0] PAL_BASE = 14'h3F00;

    typedef struct packed {
        logic       active;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic [7:0] ctrl_bits;
    } t_split;

    // Packed so that read_data lands in the low bits of tdata
    typedef struct packed {
        logic [7:0] split_ctrl_bits;
        logic [7:0] split_scroll_y;
        logic [7:0] split_scroll_x;
        logic       split_active;
        logic [7:0] read_data;
    } t_result;

    function automatic logic [10:0] nt_index(input logic [1:0] mode, input logic [13:0] addr);
        logic bank;
        case (mode)
            MIR_VERT:  bank = addr[10];
            MIR_HORZ:  bank = addr[11];
            MIR_ONE_A: bank = 1'b0;
            default:   bank = 1'b1;
        endcase
        return {bank, addr[9:0]};
    endfunction

    // Entries 10/14/18/1C alias 00/04/08/0C
    function automatic logic [4:0] pal_index(input logic [13:0] addr);
        logic [4:0] idx;
        idx = addr[4:0];
        if (idx[4] && idx[1:0] == 2'b00) begin
            idx[4] = 1'b0;
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/video_register_file_vram_port.sv
// Picture-processor CPU register file with its video memory port.
// Depends on vrf_pkg (codes, result layout, nametable/palette index helpers).

// One request per clock: a CPU write or read of one of the eight registers,
// or a status event that ORs bits 7:5 into the status register. Every request
// yields exactly one result carrying the read byte (zero for writes/events)
// and the current split-screen copy (flag, scroll x/y, control bits 5:3).
// Scalar state updates when a request is accepted; pattern, nametable,
// palette and sprite bytes sit in synchronous memories read at accept time,
// so read data and the read buffer are settled in the cycle after, in the second
// stage and results leave in order through a three-entry output queue.
// Sustained rate is one request per cycle while the output queue has room. A
// result passes through the second stage and then the output queue before it
// shows on the master side; s_axis_tready drops when three results are in flight
// and unclaimed, and during the clearing pass. After reset a clearing pass
// zeroes the pattern and nametable memories with s_axis_tready low;
// configuration writes are taken throughout. Sprite and palette memories use
// per-entry valid bits instead.
// Configuration (mirroring mode, pattern read-only) is meant to change only
// while no request is in flight.

module video_register_file_vram_port #(
    parameter int PATTERN_BYTES   = 8192,
    parameter int NAMETABLE_BYTES = 2048,
    parameter int SPRITE_BYTES    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request: [1:0] cmd, [4:2] reg_index, [12:5] write_data, [15:13] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Result: [7:0] read_data, [8] split_active, [16:9] split_scroll_x,
    // [24:17] split_scroll_y, [32:25] split_ctrl_bits, [39:33] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_wdata
);
    import vrf_pkg::*;

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam logic [PAT_AW:0]   NT_LIM   = (PAT_AW + 1)'(NAMETABLE_BYTES);
    localparam logic [PAT_AW-1:0] CLR_LAST = PAT_AW'(PATTERN_BYTES - 1);

    // ---------------- request decode ----------------
    t_cmd       req_cmd;
    t_reg       req_reg;
    logic [7:0] req_val;
    logic       acc;

    assign req_cmd = t_cmd'(s_axis_tdata[1:0]);
    assign req_reg = t_reg'(s_axis_tdata[4:2]);
    assign req_val = s_axis_tdata[12:5];
    assign acc     = s_axis_tvalid & s_axis_tready;

    // ---------------- configuration ----------------
    logic [1:0] r_mirror;
    logic       r_pat_rom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror  <= MIR_VERT;
            r_pat_rom <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MIRROR:  r_mirror  <= i_cfg_wdata;
                CFG_PAT_ROM: r_pat_rom <= i_cfg_wdata[0];
                default:     r_mirror  <= r_mirror;
            endcase
        end
    end

    // ---------------- scalar state ----------------
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_spr_addr, n_spr_addr;
    logic [7:0]  r_scroll_x, n_scroll_x;
    logic [7:0]  r_scroll_y, n_scroll_y;
    logic [14:0] r_temp, n_temp;
    logic [13:0] r_vram, n_vram;
    logic        r_first_wr, n_first_wr;
    logic [1:0]  r_stat_cnt, n_stat_cnt;
    t_split      r_split, n_split;

    // clearing pass
    logic              r_clr_busy;
    logic [PAT_AW-1:0] r_clr_addr;

    // memory controls
    logic              pat_we, nt_we, pal_we, spr_we;
    logic [PAT_AW-1:0] pat_addr, pat_waddr;
    logic [NT_AW-1:0]  nt_addr, nt_waddr;
    logic [4:0]        pal_addr;
    logic [SPR_AW-1:0] spr_addr;
    logic [7:0]        mem_wdata;

    // second stage info
    t_kind      n_kind;
    logic [7:0] n_imm;

    logic [13:0] vram_step;
    logic        vram_is_pat, vram_is_pal;

    assign vram_step   = r_vram + (r_ctrl[2] ? 14'd32 : 14'd1);
    assign vram_is_pat = r_vram < NT_BASE;
    assign vram_is_pal = r_vram >= PAL_BASE;

    // read/write addresses follow the current pointers
    assign pat_addr = PAT_AW'(r_vram);
    assign nt_addr  = NT_AW'(nt_index(r_mirror, r_vram));
    assign pal_addr = pal_index(r_vram);
    assign spr_addr = r_spr_addr[SPR_AW-1:0];

    always_comb begin
        n_ctrl     = r_ctrl;
        n_mask     = r_mask;
        n_status   = r_status;
        n_spr_addr = r_spr_addr;
        n_scroll_x = r_scroll_x;
        n_scroll_y = r_scroll_y;
        n_temp     = r_temp;
        n_vram     = r_vram;
        n_first_wr = r_first_wr;
        n_stat_cnt = r_stat_cnt;
        n_split    = r_split;
        n_kind     = K_IMM;
        n_imm      = 8'h00;
        pat_we     = 1'b0;
        nt_we      = 1'b0;
        pal_we     = 1'b0;
        spr_we     = 1'b0;
        if (acc) begin
            case (req_cmd)
                CMD_WRITE: begin
                    case (req_reg)
                        REG_CTRL: begin
                            n_ctrl = req_val;
                            n_temp = (r_temp & 15'h73FF) | {3'b000, req_val[1:0], 10'h000};
                        end
                        REG_MASK:     n_mask = req_val;
                        REG_OAM_ADDR: n_spr_addr = req_val;
                        REG_OAM_DATA: begin
                            spr_we     = 1'b1;
                            n_spr_addr = r_spr_addr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (r_first_wr) begin
                                n_scroll_x = req_val;
                                n_temp     = (r_temp & 15'h7FE0) | {10'h000, req_val[7:3]};
                                n_first_wr = 1'b0;
                            end else begin
                                n_scroll_y = req_val;
                                n_temp     = (r_temp & 15'h0C1F) | {req_val[2:0], 12'h000}
                                             | {5'h00, req_val[7:3], 5'h00};
                                n_first_wr = 1'b1;
                            end
                        end
                        REG_ADDR: begin
                            if (r_first_wr) begin
                                n_temp     = (r_temp & 15'h00FF) | {1'b0, req_val[5:0], 8'h00};
                                n_vram     = {req_val[5:0], 8'h00};
                                n_first_wr = 1'b0;
                            end else begin
                                n_temp     = {r_temp[14:8], req_val};
                                n_vram     = n_temp[13:0];
                                n_first_wr = 1'b1;
                            end
                            n_kind = K_CLR;
                        end
                        REG_DATA: begin
                            if (vram_is_pat) begin
                                pat_we = !r_pat_rom;
                            end else if (!vram_is_pal) begin
                                nt_we = 1'b1;
                            end else begin
                                pal_we = 1'b1;
                            end
                            n_vram = vram_step;
                        end
                        default: n_ctrl = r_ctrl;   // status is read-only
                    endcase
                end
                CMD_READ: begin
                    case (req_reg)
                        REG_CTRL:     n_imm = r_ctrl;
                        REG_MASK:     n_imm = r_mask;
                        REG_OAM_ADDR: n_imm = r_spr_addr;
                        REG_OAM_DATA: n_kind = K_SPR;
                        REG_SCROLL:   n_imm = r_scroll_x;
                        REG_ADDR:     n_imm = {2'b00, r_vram[13:8]};
                        REG_STATUS: begin
                            // sprite-0 pulse: a pending hit is consumed, else
                            // the third read raises one and latches the split copy
                            if (r_status[6]) begin
                                n_status[6]    = 1'b0;
                                n_stat_cnt     = 2'd0;
                                n_split.active = 1'b1;
                            end else begin
                                n_stat_cnt = r_stat_cnt + 2'd1;
                                if (n_stat_cnt == 2'd3) begin
                                    n_split.scroll_x  = r_scroll_x;
                                    n_split.scroll_y  = r_scroll_y;
                                    n_split.ctrl_bits = {2'b00, r_ctrl[5:3], 3'b000};
                                    n_split.active    = 1'b1;
                                    n_status[6]       = 1'b1;
                                    n_stat_cnt        = 2'd0;
                                end
                            end
                            n_imm       = {n_status[7:5], 5'h00};
                            n_status[7] = 1'b0;
                            n_first_wr  = 1'b1;
                        end
                        default: begin  // data port
                            if (vram_is_pat) begin
                                n_kind = K_BUF_PAT;
                            end else if (!vram_is_pal) begin
                                n_kind = K_BUF_NT;
                            end else begin
                                n_kind = K_PAL;
                            end
                            n_vram = vram_step;
                        end
                    endcase
                end
                CMD_EVENT: n_status = r_status | {req_val[7:5], 5'h00};
                default:   n_status = r_status;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= 8'h00;
            r_mask     <= 8'h00;
            r_status   <= 8'h00;
            r_spr_addr <= 8'h00;
            r_scroll_x <= 8'h00;
            r_scroll_y <= 8'h00;
            r_temp     <= 15'h0000;
            r_vram     <= 14'h0000;
            r_first_wr <= 1'b1;
            r_stat_cnt <= 2'd0;
            r_split    <= '0;
        end else begin
            r_ctrl     <= n_ctrl;
            r_mask     <= n_mask;
            r_status   <= n_status;
            r_spr_addr <= n_spr_addr;
            r_scroll_x <= n_scroll_x;
            r_scroll_y <= n_scroll_y;
            r_temp     <= n_temp;
            r_vram     <= n_vram;
            r_first_wr <= n_first_wr;
            r_stat_cnt <= n_stat_cnt;
            r_split    <= n_split;
        end
    end

    // ---------------- clearing pass ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign mem_wdata = r_clr_busy ? 8'h00 : req_val;
    assign pat_waddr = r_clr_busy ? r_clr_addr : pat_addr;
    assign nt_waddr  = r_clr_busy ? r_clr_addr[NT_AW-1:0] : nt_addr;

    // ---------------- memories ----------------
    logic [7:0] r_pat_mem [PATTERN_BYTES];
    logic [7:0] r_nt_mem  [NAMETABLE_BYTES];
    logic [7:0] r_pal_mem [32];
    logic [7:0] r_spr_mem [SPRITE_BYTES];
    logic [7:0] r_pat_q, r_nt_q, r_pal_q, r_spr_q;

    logic [31:0]             r_pal_vld;
    logic [SPRITE_BYTES-1:0] r_spr_vld;
    logic                    r_pal_vq, r_spr_vq;

    always_ff @(posedge i_clk) begin
        if (pat_we || r_clr_busy) begin
            r_pat_mem[pat_waddr] <= mem_wdata;
        end
        r_pat_q <= r_pat_mem[pat_addr];
    end

    always_ff @(posedge i_clk) begin
        if (nt_we || (r_clr_busy && ({1'b0, r_clr_addr} < NT_LIM))) begin
            r_nt_mem[nt_waddr] <= mem_wdata;
        end
        r_nt_q <= r_nt_mem[nt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[pal_addr] <= req_val;
        end
        r_pal_q <= r_pal_mem[pal_addr];
    end

    always_ff @(posedge i_clk) begin
        if (spr_we) begin
            r_spr_mem[spr_addr] <= req_val;
        end
        r_spr_q <= r_spr_mem[spr_addr];
    end

    // never-written palette/sprite entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_spr_vld <= '0;
            r_pal_vq  <= 1'b0;
            r_spr_vq  <= 1'b0;
        end else begin
            if (pal_we) begin
                r_pal_vld[pal_addr] <= 1'b1;
            end
            if (spr_we) begin
                r_spr_vld[spr_addr] <= 1'b1;
            end
            r_pal_vq <= r_pal_vld[pal_addr];
            r_spr_vq <= r_spr_vld[spr_addr];
        end
    end

    // ---------------- second stage ----------------
    logic       r_s1_vld;
    t_kind      r_s1_kind;
    logic [7:0] r_s1_imm;
    t_split     r_s1_split;
    logic [7:0] r_rd_buf, n_rd_buf;
    logic [7:0] s1_rdata;
    t_result    s1_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind  <= n_kind;
        r_s1_imm   <= n_imm;
        r_s1_split <= n_split;
    end

    // read buffer lives here so back-to-back data reads see it in order
    always_comb begin
        s1_rdata = r_s1_imm;
        n_rd_buf = r_rd_buf;
        case (r_s1_kind)
            K_SPR: s1_rdata = r_spr_vq ? r_spr_q : 8'h00;
            K_PAL: begin
                s1_rdata = r_pal_vq ? {2'b00, r_pal_q[5:0]} : 8'h00;
                n_rd_buf = r_nt_q;
            end
            K_BUF_PAT: begin
                s1_rdata = r_rd_buf;
                n_rd_buf = r_pat_q;
            end
            K_BUF_NT: begin
                s1_rdata = r_rd_buf;
                n_rd_buf = r_nt_q;
            end
            K_CLR:   n_rd_buf = 8'h00;
            default: s1_rdata = r_s1_imm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_buf <= 8'h00;
        end else if (r_s1_vld) begin
            r_rd_buf <= n_rd_buf;
        end
    end

    assign s1_res = '{split_ctrl_bits: r_s1_split.ctrl_bits,
                      split_scroll_y:  r_s1_split.scroll_y,
                      split_scroll_x:  r_s1_split.scroll_x,
                      split_active:    r_s1_split.active,
                      read_data:       s1_rdata};

    // ---------------- output queue ----------------
    t_result    r_fifo [3];
    logic [1:0] r_wr_ptr, r_rd_ptr, r_count;
    logic [2:0] inflight;
    logic       pop;

    assign pop           = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = r_count != 2'd0;
    assign m_axis_tdata  = {7'h00, r_fifo[r_rd_ptr]};
    assign inflight      = {2'b00, r_s1_vld} + {1'b0, r_count};
    assign s_axis_tready = !r_clr_busy && (inflight < 3'd3);

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fifo[r_wr_ptr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
        end else begin
            if (r_s1_vld) begin
                r_wr_ptr <= (r_wr_ptr == 2'd2) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'd2) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {1'b0, r_s1_vld} - {1'b0, pop};
        end
    end

endmodule
